// ===== rtl/edrb_pkg.sv =====
`timescale 1ns / 1ps
// edrb_pkg: widths, constants, types and helpers for the ellipsoid root bisector
// no dependencies; used by edrb_if.sv, edrb_addsub.sv and the top level

package edrb_pkg;

  localparam int VW        = 48;             // value width
  localparam int FB        = 16;             // fraction bits
  localparam int MAX_STEPS = 64;             // midpoint evaluations at most
  localparam int AXES      = 3;
  localparam int CFG_W     = 17;             // stop width register

  localparam int ACC_W  = 2 * VW + 2;        // sum of squared products
  localparam int MC_W   = 2 * VW;            // shifted multiplicand
  localparam int RAD_W  = ACC_W + (ACC_W % 2); // radicand, even
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int NUM_W  = VW + FB;           // divide numerator
  localparam int DEN_W  = VW + 1;            // t + square
  localparam int Q_W    = FB + 1;            // capped quotient
  localparam int QSQ_W  = 2 * Q_W;
  localparam int FS_W   = QSQ_W + 2;         // sum of squared quotients
  localparam int RES_W  = NUM_W;             // quotient / root shift register
  localparam int UW     = RAD_W;             // shared adder width
  localparam int CNT_W  = 7;
  localparam int AX_W   = 2;

  localparam logic [Q_W-1:0]  CAP    = Q_W'((1 << FB) + 1);
  localparam logic [FS_W-1:0] ONE_FX = FS_W'(1) << (2 * FB);
  localparam logic [VW-1:0]   VMAX   = {VW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_ROOT_END,
    ST_EV_SETUP,
    ST_DIV,
    ST_DIV_END,
    ST_ACC,
    ST_EV_END,
    ST_CHECK,
    ST_MIDP,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_LOW,
    PH_HIGH,
    PH_MID
  } phase_e;

  typedef struct packed {
    logic signed [VW-1:0] axis_pos_x;
    logic signed [VW-1:0] axis_pos_y;
    logic signed [VW-1:0] axis_pos_z;
    logic [VW-1:0]        axis_sq_x;
    logic [VW-1:0]        axis_sq_y;
    logic [VW-1:0]        axis_sq_z;
  } in_item_t;

  typedef struct packed {
    logic [VW-1:0] root_value;
    logic          inside_flag;
  } out_item_t;

  // absolute value of a two's complement product
  function automatic logic [VW-1:0] mag(input logic [VW-1:0] raw);
    return raw[VW-1] ? (~raw + VW'(1)) : raw;
  endfunction

endpackage

// ===== rtl/edrb_if.sv =====
`timescale 1ns / 1ps
// edrb_if: valid/ready channels for items, results and the stop width write
// depends on edrb_pkg

interface edrb_in_if;
  import edrb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edrb_out_if;
  import edrb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edrb_cfg_if;
  import edrb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/edrb_addsub.sv =====
`timescale 1ns / 1ps
// edrb_addsub: the shared wide add/subtract unit of the bisector
// depends on edrb_pkg

module edrb_addsub (
  input  logic [edrb_pkg::UW-1:0] a_i,
  input  logic [edrb_pkg::UW-1:0] b_i,
  input  logic                    sub_i,
  output logic [edrb_pkg::UW-1:0] sum_o,
  output logic                    co_o
);
  import edrb_pkg::*;

  logic [UW-1:0] b_eff;

  // on subtract, carry out set means a >= b
  assign b_eff = sub_i ? ~b_i : b_i;
  assign {co_o, sum_o} = {1'b0, a_i} + {1'b0, b_eff} + {{UW{1'b0}}, sub_i};

endmodule

// ===== rtl/ellipsoid_distance_root_bisector_core.sv =====
`timescale 1ns / 1ps
// ellipsoid_distance_root_bisector_core: sequencer and registers of the bisector
// depends on edrb_pkg, edrb_if and edrb_addsub
//
//   channel  dir  interface          carries
//   in_i     in   edrb_in_if.sink    three signed products, three squared semi-axes
//   out_o    out  edrb_out_if.source root value and inside flag
//   cfg_i    in   edrb_cfg_if.sink   stop width (17 bits), always ready
//
// one request is worked at a time through a single wide adder/subtractor:
// squares of the products use shift-add, the square root takes two radicand bits
// per cycle, and each evaluation of f works axis by axis through setup, a
// restoring divide, square and sum; an empty bracket ends right after the square
// root without any evaluation of f
// reset clears the sequencer, the result valid and sets stop width to 1
// a new request is taken while the previous result still waits on out_o

module ellipsoid_distance_root_bisector_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  edrb_in_if.sink    in_i,
  edrb_out_if.source out_o,
  edrb_cfg_if.sink   cfg_i
);
  import edrb_pkg::*;

  // control state
  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [AX_W-1:0]  axis_q, axis_d;
  logic             out_valid_q, out_valid_d;
  logic [CFG_W-1:0] stop_q;

  // held item
  logic [VW-1:0] prod_q [AXES];
  logic [VW-1:0] sq_q [AXES];

  // datapath registers
  logic [ACC_W-1:0]  acc_q, acc_d;       // sum of squared products
  logic [MC_W-1:0]   mcand_q, mcand_d;
  logic [VW-1:0]     mplier_q, mplier_d;
  logic [RAD_W-1:0]  sh_q, sh_d;         // radicand or numerator bits
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [RES_W-1:0]  res_q, res_d;       // root or quotient bits
  logic [DEN_W-1:0]  den_q, den_d;
  logic [QSQ_W-1:0]  qsq_q, qsq_d;
  logic [FS_W-1:0]   fsum_q, fsum_d;
  logic [VW-1:0]     low_q, low_d;
  logic [VW-1:0]     high_q, high_d;
  logic [VW-1:0]     t_q, t_d;
  logic [VW-1:0]     width_q, width_d;
  logic              low_sign_q, low_sign_d;
  logic              fl_zero_q, fl_zero_d;
  logic              fl_pos_q, fl_pos_d;
  logic [VW-1:0]     rroot_q, rroot_d;
  logic              rin_q, rin_d;
  out_item_t         out_q, out_d;

  // shared unit
  logic [UW-1:0] ua, ub, usum;
  logic          usub, uco;

  edrb_addsub u_addsub (
    .a_i  (ua),
    .b_i  (ub),
    .sub_i(usub),
    .sum_o(usum),
    .co_o (uco)
  );

  // helper values
  logic [VW-1:0]   cur_mag;
  logic [VW-1:0]   hi_sat;
  logic [VW-1:0]   mid;
  logic [Q_W-1:0]  qc;
  logic            f_pos, f_zero;
  logic            last_axis;

  assign cur_mag   = mag(prod_q[axis_q]);
  assign hi_sat    = (res_q[ROOT_W-1:0] > ROOT_W'(VMAX)) ? VMAX : res_q[VW-1:0];
  assign mid       = low_q + (width_q >> 1);
  assign qc        = (res_q > RES_W'(CAP)) ? CAP : res_q[Q_W-1:0];
  assign f_pos     = fsum_q > ONE_FX;
  assign f_zero    = fsum_q == ONE_FX;
  assign last_axis = axis_q == AX_W'(AXES - 1);

  assign in_i.ready  = state_q == ST_IDLE;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // operand select for the shared unit
  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    unique case (state_q)
      ST_SQR: begin
        ua = UW'(acc_q);
        ub = UW'(mcand_q);
      end
      ST_ROOT: begin
        ua   = UW'({rem_q, sh_q[RAD_W-1 -: 2]});
        ub   = UW'({res_q[ROOT_W-1:0], 2'b01});
        usub = 1'b1;
      end
      ST_EV_SETUP: begin
        ua = UW'(t_q);
        ub = UW'(sq_q[axis_q]);
      end
      ST_DIV: begin
        ua   = UW'({rem_q[DEN_W-1:0], sh_q[RAD_W-1]});
        ub   = UW'(den_q);
        usub = 1'b1;
      end
      ST_ACC: begin
        ua = UW'(fsum_q);
        ub = UW'(qsq_q);
      end
      ST_CHECK: begin
        ua   = UW'(high_q);
        ub   = UW'(low_q);
        usub = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_o.ready;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    res_d       = res_q;
    den_d       = den_q;
    qsq_d       = qsq_q;
    fsum_d      = fsum_q;
    low_d       = low_q;
    high_d      = high_q;
    t_d         = t_q;
    width_d     = width_q;
    low_sign_d  = low_sign_q;
    fl_zero_d   = fl_zero_q;
    fl_pos_d    = fl_pos_q;
    rroot_d     = rroot_q;
    rin_d       = rin_q;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mplier_d = mag(in_i.data.axis_pos_x);
          mcand_d  = MC_W'(mag(in_i.data.axis_pos_x));
          acc_d    = '0;
          axis_d   = '0;
          cnt_d    = '0;
          state_d  = ST_SQR;
        end
      end

      // shift-add square of each product magnitude
      ST_SQR: begin
        if (mplier_q[0]) acc_d = usum[ACC_W-1:0];
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VW - 1)) begin
          cnt_d = '0;
          if (last_axis) begin
            sh_d    = RAD_W'(acc_d);
            rem_d   = '0;
            res_d   = '0;
            state_d = ST_ROOT;
          end else begin
            axis_d   = axis_q + AX_W'(1);
            mplier_d = mag(prod_q[axis_q + AX_W'(1)]);
            mcand_d  = MC_W'(mag(prod_q[axis_q + AX_W'(1)]));
          end
        end
      end

      // digit-by-digit square root, two radicand bits per cycle
      ST_ROOT: begin
        if (uco) rem_d = usum[REM_W-1:0];
        else rem_d = ua[REM_W-1:0];
        res_d = {res_q[RES_W-2:0], uco};
        sh_d  = sh_q << 2;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = ST_ROOT_END;
      end

      ST_ROOT_END: begin
        low_d  = '0;
        high_d = hi_sat;
        step_d = '0;
        low_sign_d = 1'b0;
        if (hi_sat == '0) begin
          rroot_d = '0;
          rin_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          phase_d = PH_LOW;
          t_d     = '0;
          axis_d  = '0;
          fsum_d  = '0;
          state_d = ST_EV_SETUP;
        end
      end

      // one axis term of f(t): den = t + square
      ST_EV_SETUP: begin
        den_d = usum[DEN_W-1:0];
        if (cur_mag == '0) begin
          if (last_axis) state_d = ST_EV_END;
          else axis_d = axis_q + AX_W'(1);
        end else if (usum[DEN_W-1:0] == '0) begin
          qsq_d   = CAP * CAP;
          state_d = ST_ACC;
        end else begin
          sh_d    = {cur_mag, {(RAD_W - VW){1'b0}}};
          rem_d   = '0;
          res_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end

      // restoring divide of mag * 2^FB by den
      ST_DIV: begin
        if (uco) rem_d = usum[REM_W-1:0];
        else rem_d = ua[REM_W-1:0];
        res_d = {res_q[RES_W-2:0], uco};
        sh_d  = sh_q << 1;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) state_d = ST_DIV_END;
      end

      ST_DIV_END: begin
        qsq_d   = qc * qc;
        state_d = ST_ACC;
      end

      ST_ACC: begin
        fsum_d = usum[FS_W-1:0];
        if (last_axis) begin
          state_d = ST_EV_END;
        end else begin
          axis_d  = axis_q + AX_W'(1);
          state_d = ST_EV_SETUP;
        end
      end

      // sign of f against one
      ST_EV_END: begin
        axis_d = '0;
        fsum_d = '0;
        unique case (phase_q)
          PH_LOW: begin
            fl_zero_d = f_zero;
            fl_pos_d  = f_pos;
            phase_d   = PH_HIGH;
            t_d       = high_q;
            state_d   = ST_EV_SETUP;
          end
          PH_HIGH: begin
            rin_d   = 1'b0;
            rroot_d = '0;
            state_d = ST_DONE;
            if (fl_zero_q) begin
              rroot_d = '0;
            end else if (f_zero) begin
              rroot_d = high_q;
            end else if (fl_pos_q == f_pos) begin
              rin_d = 1'b1;
            end else begin
              low_sign_d = fl_pos_q;
              state_d    = ST_CHECK;
            end
          end
          PH_MID: begin
            if (f_zero) begin
              low_d   = t_q;
              high_d  = t_q;
              rroot_d = t_q;
              rin_d   = 1'b0;
              state_d = ST_DONE;
            end else begin
              if (f_pos == low_sign_q) low_d = t_q;
              else high_d = t_q;
              state_d = ST_CHECK;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_CHECK: begin
        width_d = usum[VW-1:0];
        state_d = ST_MIDP;
      end

      // stop tests, else evaluate at the midpoint
      ST_MIDP: begin
        if (step_q == CNT_W'(MAX_STEPS) || width_q <= VW'(stop_q) ||
            mid == low_q || mid == high_q) begin
          rroot_d = mid;
          rin_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          t_d     = mid;
          phase_d = PH_MID;
          step_d  = step_q + CNT_W'(1);
          axis_d  = '0;
          fsum_d  = '0;
          state_d = ST_EV_SETUP;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.root_value  = rroot_q;
          out_d.inside_flag = rin_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LOW;
      cnt_q       <= '0;
      step_q      <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      stop_q      <= CFG_W'(1);
      low_sign_q  <= 1'b0;
      fl_zero_q   <= 1'b0;
      fl_pos_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      low_sign_q  <= low_sign_d;
      fl_zero_q   <= fl_zero_d;
      fl_pos_q    <= fl_pos_d;
      if (cfg_i.valid) stop_q <= cfg_i.data;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      prod_q[0] <= in_i.data.axis_pos_x;
      prod_q[1] <= in_i.data.axis_pos_y;
      prod_q[2] <= in_i.data.axis_pos_z;
      sq_q[0]   <= in_i.data.axis_sq_x;
      sq_q[1]   <= in_i.data.axis_sq_y;
      sq_q[2]   <= in_i.data.axis_sq_z;
    end
    acc_d_reg: begin
      acc_q    <= acc_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      sh_q     <= sh_d;
      rem_q    <= rem_d;
      res_q    <= res_d;
      den_q    <= den_d;
      qsq_q    <= qsq_d;
      fsum_q   <= fsum_d;
      low_q    <= low_d;
      high_q   <= high_d;
      t_q      <= t_d;
      width_q  <= width_d;
      rroot_q  <= rroot_d;
      rin_q    <= rin_d;
      out_q    <= out_d;
    end
  end

endmodule
